// ----- hdl/trn_pkg.sv -----
// ----------------------------------------------------------------------------
// trn_pkg
// Shared types, telnet codes and constant tables of the telnet receive
// negotiator.
// ----------------------------------------------------------------------------
package trn_pkg;

  localparam int OptionCount = 256;
  localparam int OptAw       = $clog2(OptionCount);
  localparam int QDepth      = 4;
  localparam int QAw         = $clog2(QDepth);
  localparam int AytLen      = 35;
  localparam int StartLen    = 9;

  localparam logic [7:0] TN_IAC  = 8'd255;
  localparam logic [7:0] TN_DONT = 8'd254;
  localparam logic [7:0] TN_DO   = 8'd253;
  localparam logic [7:0] TN_WONT = 8'd252;
  localparam logic [7:0] TN_WILL = 8'd251;
  localparam logic [7:0] TN_SB   = 8'd250;
  localparam logic [7:0] TN_GA   = 8'd249;
  localparam logic [7:0] TN_AYT  = 8'd246;
  localparam logic [7:0] TN_SE   = 8'd240;
  localparam logic [7:0] CH_BEL  = 8'd7;

  localparam logic [7:0] OPTN_ECHO   = 8'd1;
  localparam logic [7:0] OPTN_SGA    = 8'd3;
  localparam logic [7:0] OPTN_STATUS = 8'd5;
  localparam logic [7:0] OPTN_TMARK  = 8'd6;
  localparam logic [7:0] OPTN_TTYPE  = 8'd24;
  localparam logic [7:0] OPTN_NAWS   = 8'd31;

  // Option flag bits.
  localparam logic [3:0] F_MY    = 4'b0001;
  localparam logic [3:0] F_HIS   = 4'b0010;
  localparam logic [3:0] F_ANN   = 4'b0100;
  localparam logic [3:0] F_HEANN = 4'b1000;

  localparam logic [2:0] K_DISPLAY = 3'd0;
  localparam logic [2:0] K_BELL    = 3'd1;
  localparam logic [2:0] K_GA      = 3'd2;
  localparam logic [2:0] K_TX      = 3'd3;
  localparam logic [2:0] K_ECHO    = 3'd4;

  localparam logic [8*AytLen-1:0] AYT_STR = "I'm here! Please be more patient!\r\n";

  typedef enum logic [2:0] {
    OP_DISP = 3'd0,
    OP_BELL = 3'd1,
    OP_GA   = 3'd2,
    OP_AYT  = 3'd3,
    OP_NEG  = 3'd4,
    OP_CONN = 3'd5
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic [7:0] verb;
  } cmd_t;

  typedef struct packed {
    logic            full;
    logic            empty;
    logic [QAw:0]    count;
  } q_status_t;

  function automatic logic [7:0] ayt_char(input logic [5:0] idx);
    ayt_char = AYT_STR[(AytLen - 1 - int'(idx)) * 8 +: 8];
  endfunction

  function automatic logic [7:0] start_char(input logic [5:0] idx);
    case (idx)
      6'd0, 6'd3, 6'd6: start_char = TN_IAC;
      6'd1, 6'd7:       start_char = TN_WILL;
      6'd2:             start_char = OPTN_NAWS;
      6'd4:             start_char = TN_DONT;
      6'd5:             start_char = OPTN_ECHO;
      6'd8:             start_char = OPTN_TTYPE;
      default:          start_char = 8'd0;
    endcase
  endfunction

endpackage

// ----- hdl/trn_in_if.sv -----
// ----------------------------------------------------------------------------
// trn_in_if
// Input channel: received bytes and connect events.
// ----------------------------------------------------------------------------
interface trn_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, func, rx_byte, input ready);
  modport sink   (input valid, func, rx_byte, output ready);
endinterface

// ----- hdl/trn_out_if.sv -----
// ----------------------------------------------------------------------------
// trn_out_if
// Result channel: display, bell, go-ahead, transmit and echo words.
// ----------------------------------------------------------------------------
interface trn_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] byte_value;
  logic       echo_local;
  logic       last;

  modport source (output valid, kind, byte_value, echo_local, last, input ready);
  modport sink   (input valid, kind, byte_value, echo_local, last, output ready);
endinterface

// ----- hdl/trn_ram.sv -----
// ----------------------------------------------------------------------------
// trn_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module trn_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ----- hdl/trn_front.sv -----
// ----------------------------------------------------------------------------
// trn_front
// Telnet byte parser: tracks IAC sequences and turns each word into a
// command for the back end, or drops it.
// ----------------------------------------------------------------------------
module trn_front import trn_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  trn_in_if.sink       in_ch,
  input  q_status_t    q_stat,
  output logic         push,
  output cmd_t         push_cmd
);
  typedef enum logic [3:0] {
    M_NORM = 4'b0001,
    M_IAC  = 4'b0010,
    M_VERB = 4'b0100,
    M_SUB  = 4'b1000
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic       sub_iac_r, sub_iac_nxt;
  logic [7:0] verb_r, verb_nxt;
  logic       acc;
  logic       want;
  logic [7:0] b;

  assign in_ch.ready = !q_stat.full;
  assign acc  = in_ch.valid && in_ch.ready;
  assign b    = in_ch.rx_byte;
  assign push = acc && want;

  always_comb begin
    mode_nxt    = mode_r;
    sub_iac_nxt = sub_iac_r;
    verb_nxt    = verb_r;
    want        = 1'b0;
    push_cmd    = '{op: OP_DISP, data: b, verb: verb_r};
    if (in_ch.func) begin
      want          = 1'b1;
      push_cmd.op   = OP_CONN;
      mode_nxt      = M_NORM;
      sub_iac_nxt   = 1'b0;
      verb_nxt      = 8'd0;
    end else begin
      case (mode_r)
        M_NORM: begin
          if (b == TN_IAC) begin
            mode_nxt = M_IAC;
          end else begin
            want = 1'b1;
            push_cmd.op = (b == CH_BEL) ? OP_BELL : OP_DISP;
          end
        end
        M_IAC: begin
          mode_nxt = M_NORM;
          if (b == TN_IAC) begin
            want = 1'b1;
          end else if (b inside {TN_WILL, TN_WONT, TN_DO, TN_DONT}) begin
            verb_nxt = b;
            mode_nxt = M_VERB;
          end else if (b == TN_SB) begin
            sub_iac_nxt = 1'b0;
            mode_nxt    = M_SUB;
          end else if (b == TN_AYT) begin
            want = 1'b1;
            push_cmd.op = OP_AYT;
          end else if (b == TN_GA) begin
            want = 1'b1;
            push_cmd.op = OP_GA;
          end
        end
        M_VERB: begin
          mode_nxt    = M_NORM;
          want        = 1'b1;
          push_cmd.op = OP_NEG;
          verb_nxt    = 8'd0;
        end
        M_SUB: begin
          if (sub_iac_r) begin
            sub_iac_nxt = 1'b0;
            if (b == TN_SE) begin
              mode_nxt = M_NORM;
            end
          end else if (b == TN_IAC) begin
            sub_iac_nxt = 1'b1;
          end
        end
        default: mode_nxt = M_NORM;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_NORM;
      sub_iac_r <= 1'b0;
      verb_r    <= 8'd0;
    end else if (acc) begin
      mode_r    <= mode_nxt;
      sub_iac_r <= sub_iac_nxt;
      verb_r    <= verb_nxt;
    end
  end
endmodule

// ----- hdl/trn_queue.sv -----
// ----------------------------------------------------------------------------
// trn_queue
// Short command queue between parser and executor.
// ----------------------------------------------------------------------------
module trn_queue import trn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head,
  output q_status_t stat
);
  cmd_t           ent_r [QDepth];
  logic [QAw-1:0] wp_r, rp_r;
  logic [QAw:0]   cnt_r;

  assign head       = ent_r[rp_r];
  assign stat.count = cnt_r;
  assign stat.full  = (cnt_r == (QAw+1)'(QDepth));
  assign stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAw+1)'(push) - (QAw+1)'(pop);
    end
  end
endmodule

// ----- hdl/trn_back.sv -----
// ----------------------------------------------------------------------------
// trn_back
// Command executor: option negotiation, reply sequences and the output
// register.
// ----------------------------------------------------------------------------
module trn_back import trn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       startup_negotiate,
  input  cmd_t       head,
  input  q_status_t  q_stat,
  output logic       pop,
  trn_out_if.source  out_ch
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  cmd_t                   cmd_r, cmd_nxt;
  logic [5:0]             idx_r, idx_nxt, cnt_r, cnt_nxt;
  logic [7:0]             reply_r, reply_nxt;
  logic                   echo_r, echo_nxt;
  logic [OptionCount-1:0] ovalid_r, ovalid_nxt;
  logic                   ov_r, ov_nxt;
  logic [2:0]             okind_r, okind_nxt;
  logic [7:0]             obyte_r, obyte_nxt;
  logic                   oecho_r, oecho_nxt;
  logic                   olast_r, olast_nxt;
  logic                   can_emit, load;
  logic                   re, we;
  logic [3:0]             rdata, f, fn;
  logic                   remote_ok, local_ok, has_reply, echo_ev, echo_val;
  logic [7:0]             rverb, opt;

  assign can_emit = !ov_r || out_ch.ready;
  assign opt      = cmd_r.data;

  trn_ram #(.WIDTH(4), .DEPTH(OptionCount)) u_flags (
    .clk   (clk),
    .we    (we),
    .waddr (opt[OptAw-1:0]),
    .wdata (fn),
    .re    (re),
    .raddr (head.data[OptAw-1:0]),
    .rdata (rdata)
  );

  // Negotiation by the RFC rules on the flags of the current option.
  always_comb begin
    f         = ovalid_r[opt[OptAw-1:0]] ? rdata : 4'd0;
    fn        = f;
    remote_ok = opt inside {OPTN_SGA, OPTN_STATUS, OPTN_TTYPE, OPTN_NAWS, OPTN_ECHO};
    local_ok  = opt inside {OPTN_SGA, OPTN_STATUS, OPTN_TTYPE, OPTN_NAWS};
    has_reply = 1'b0;
    rverb     = TN_DONT;
    echo_ev   = 1'b0;
    echo_val  = echo_r;
    case (cmd_r.verb)
      TN_WILL: begin
        fn = f | F_HEANN;
        if ((f & F_HIS) == 4'd0) begin
          has_reply = 1'b1;
          if (remote_ok) begin
            rverb = TN_DO;
            fn    = f | F_HEANN | F_HIS;
            if (opt == OPTN_ECHO) begin
              echo_ev  = 1'b1;
              echo_val = 1'b0;
            end
          end
        end
      end
      TN_WONT: begin
        fn = f | F_HEANN;
        if (((f & F_HIS) != 4'd0) || ((f & F_HEANN) == 4'd0)) begin
          has_reply = 1'b1;
          fn        = (f | F_HEANN) & ~F_HIS;
          if (opt == OPTN_ECHO) begin
            echo_ev  = 1'b1;
            echo_val = 1'b1;
          end
        end
      end
      TN_DO: begin
        if (opt == OPTN_TMARK) begin
          has_reply = 1'b1;
          rverb     = TN_WILL;
        end else if ((f & F_MY) == 4'd0) begin
          has_reply = 1'b1;
          rverb     = local_ok ? TN_WILL : TN_WONT;
          fn        = local_ok ? (f | F_MY | F_ANN) : (f | F_ANN);
        end
      end
      default: begin
        rverb = TN_WONT;
        if (((f & F_MY) != 4'd0) || ((f & F_ANN) == 4'd0)) begin
          has_reply = 1'b1;
          fn        = (f | F_ANN) & ~F_MY;
        end else begin
          fn = f & ~F_MY;
        end
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    reply_nxt  = reply_r;
    echo_nxt   = echo_r;
    ovalid_nxt = ovalid_r;
    pop        = 1'b0;
    re         = 1'b0;
    we         = 1'b0;
    load       = 1'b0;
    okind_nxt  = okind_r;
    obyte_nxt  = obyte_r;
    oecho_nxt  = oecho_r;
    olast_nxt  = olast_r;
    case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          cmd_nxt = head;
          idx_nxt = 6'd0;
          case (head.op)
            OP_DISP, OP_BELL, OP_GA: begin
              if (can_emit) begin
                pop       = 1'b1;
                load      = 1'b1;
                okind_nxt = (head.op == OP_DISP) ? K_DISPLAY :
                            (head.op == OP_BELL) ? K_BELL : K_GA;
                obyte_nxt = (head.op == OP_DISP) ? head.data : 8'd0;
                oecho_nxt = 1'b0;
                olast_nxt = 1'b1;
              end
            end
            OP_NEG: begin
              pop       = 1'b1;
              re        = 1'b1;
              state_nxt = S_RD;
            end
            OP_AYT: begin
              pop       = 1'b1;
              cnt_nxt   = 6'(AytLen);
              state_nxt = S_EMIT;
            end
            default: begin
              pop        = 1'b1;
              ovalid_nxt = '0;
              cnt_nxt    = 6'(StartLen);
              if (startup_negotiate) state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_RD: begin
        we                      = 1'b1;
        ovalid_nxt[opt[OptAw-1:0]] = 1'b1;
        reply_nxt               = rverb;
        echo_nxt                = echo_val;
        cnt_nxt                 = echo_ev ? 6'd4 : 6'd3;
        state_nxt               = has_reply ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (can_emit) begin
          load      = 1'b1;
          okind_nxt = K_TX;
          oecho_nxt = 1'b0;
          olast_nxt = (idx_r == cnt_r - 6'd1);
          case (cmd_r.op)
            OP_AYT:  obyte_nxt = ayt_char(idx_r);
            OP_NEG: begin
              case (idx_r)
                6'd0:    obyte_nxt = TN_IAC;
                6'd1:    obyte_nxt = reply_r;
                6'd2:    obyte_nxt = opt;
                default: begin
                  obyte_nxt = 8'd0;
                  okind_nxt = K_ECHO;
                  oecho_nxt = echo_r;
                end
              endcase
            end
            default: obyte_nxt = start_char(idx_r);
          endcase
          idx_nxt = idx_r + 6'd1;
          if (idx_r == cnt_r - 6'd1) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    ov_nxt = load || (ov_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      idx_r    <= 6'd0;
      cnt_r    <= 6'd0;
      echo_r   <= 1'b0;
      ovalid_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      cnt_r    <= cnt_nxt;
      echo_r   <= echo_nxt;
      ovalid_r <= ovalid_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    reply_r <= reply_nxt;
    if (load) begin
      okind_r <= okind_nxt;
      obyte_r <= obyte_nxt;
      oecho_r <= oecho_nxt;
      olast_r <= olast_nxt;
    end
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.kind       = okind_r;
  assign out_ch.byte_value = obyte_r;
  assign out_ch.echo_local = oecho_r;
  assign out_ch.last       = olast_r;
endmodule

// ----- hdl/telnet_receive_negotiator_top.sv -----
// ----------------------------------------------------------------------------
// telnet_receive_negotiator_top
// Telnet receive parser with option negotiation and reply generation.
// ----------------------------------------------------------------------------
// Received words enter on in_ch (func 0 is a link byte, func 1 a connect
// event) and results leave on out_ch, each marked last on the final word
// that one input causes; an input that causes nothing gives no word. Plain
// data, bell and go-ahead words pass at one word per cycle while the
// executor is idle and out_ch ready. A negotiation reads and updates the
// option flags, then gives three or four words; an AYT reply is 35 words
// and the startup offers nine. The parser runs ahead of the executor via a
// four-entry command queue, so input stalls only when that queue fills
// behind a long reply or stalled output. Option flags live in a 256-entry
// RAM with one valid bit per option, so a connect event clears all flags.
// cfg_we writes cfg_wdata into startup_negotiate; write it only while idle.
module telnet_receive_negotiator_top import trn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  trn_in_if.sink    in_ch,
  trn_out_if.source out_ch
);
  logic      startup_r;
  logic      push, pop;
  cmd_t      push_cmd, head;
  q_status_t q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      startup_r <= 1'b0;
    end else if (cfg_we) begin
      startup_r <= cfg_wdata;
    end
  end

  // Parser: keeps the IAC sequence state and emits at most one command per word.
  trn_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  trn_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // Executor: negotiation, reply sequences and the output register.
  trn_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .startup_negotiate (startup_r),
    .head              (head),
    .q_stat            (q_stat),
    .pop               (pop),
    .out_ch            (out_ch)
  );

  // The queue never pushes when full nor pops when empty.
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= (QAw+1)'(QDepth))
    else $error("command queue overflow");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty command queue");

  // An echo change is always the final word of its negotiation.
  a_echo_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind == K_ECHO) |-> out_ch.last)
    else $error("echo change not last");
endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the telnet receive negotiator: a directed table of
// telnet sequences followed by random streams of negotiations, commands,
// subnegotiations and data, all checked word by word against a predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import trn_pkg::*;

  // Expected output word.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] byte_value;
    logic       echo_local;
    logic       last;
  } word_t;

  // One directed stimulus row. When has_exp is set, the row's first expected
  // word is also compared against the typed-in value.
  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
    logic       has_exp;
    word_t      exp_word;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  trn_in_if  in_ch ();
  trn_out_if out_ch ();

  telnet_receive_negotiator_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source)
  );

  // Predictor state, a private copy of what the block keeps.
  logic [3:0] opt_flags [OptionCount];
  logic [1:0] parse_st;
  logic       sub_iac;
  logic [7:0] held_verb;
  logic       echo_st;
  logic       startup_en;

  word_t expected_words [$];
  word_t step_words [$];
  int    mismatch_count;
  int    idle_cycles;
  bit    long_hold;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    $display("MISMATCH %s: got k=%0d b=%0d e=%0d l=%0d, want k=%0d b=%0d e=%0d l=%0d",
             what, got.kind, got.byte_value, got.echo_local, got.last,
             want.kind, want.byte_value, want.echo_local, want.last);
    mismatch_count++;
  endtask

  function automatic void push_word(input logic [2:0] k, input logic [7:0] b,
                                    input logic e);
    word_t w;
    w.kind = k;
    w.byte_value = b;
    w.echo_local = e;
    w.last = 1'b0;
    step_words.push_back(w);
  endfunction

  function automatic void push_triplet(input logic [7:0] verb, input logic [7:0] opt);
    push_word(K_TX, TN_IAC, 1'b0);
    push_word(K_TX, verb, 1'b0);
    push_word(K_TX, opt, 1'b0);
  endfunction

  function automatic void clear_session();
    foreach (opt_flags[i]) opt_flags[i] = 4'd0;
    parse_st  = 2'd0;
    sub_iac   = 1'b0;
    held_verb = 8'd0;
  endfunction

  // RFC 854 style answer to one verb/option pair.
  function automatic void answer_option(input logic [7:0] verb, input logic [7:0] opt);
    logic [3:0] f;
    bit remote_ok;
    bit local_ok;
    f = opt_flags[opt];
    local_ok  = (opt == OPTN_SGA) || (opt == OPTN_STATUS) || (opt == OPTN_TTYPE) ||
                (opt == OPTN_NAWS);
    remote_ok = local_ok || (opt == OPTN_ECHO);
    if (verb == TN_WILL) begin
      f |= F_HEANN;
      if ((f & F_HIS) == 4'd0) begin
        if (remote_ok) begin
          push_triplet(TN_DO, opt);
          f |= F_HIS;
          if (opt == OPTN_ECHO) begin
            echo_st = 1'b0;
            push_word(K_ECHO, 8'd0, echo_st);
          end
        end else begin
          push_triplet(TN_DONT, opt);
        end
      end
    end else if (verb == TN_WONT) begin
      if ((f & F_HIS) != 4'd0 || (f & F_HEANN) == 4'd0) begin
        push_triplet(TN_DONT, opt);
        f &= ~F_HIS;
        if (opt == OPTN_ECHO) begin
          echo_st = 1'b1;
          push_word(K_ECHO, 8'd0, echo_st);
        end
      end
      f |= F_HEANN;
    end else if (verb == TN_DO) begin
      if (opt == OPTN_TMARK) begin
        push_triplet(TN_WILL, opt);
      end else if ((f & F_MY) == 4'd0) begin
        if (local_ok) begin
          push_triplet(TN_WILL, opt);
          f |= F_MY;
        end else begin
          push_triplet(TN_WONT, opt);
        end
        f |= F_ANN;
      end
    end else begin
      if ((f & F_MY) != 4'd0 || (f & F_ANN) == 4'd0) begin
        push_triplet(TN_WONT, opt);
        f |= F_ANN;
      end
      f &= ~F_MY;
    end
    opt_flags[opt] = f;
  endfunction

  // Works out the words one accepted input causes; they land in step_words.
  function automatic void predict_telnet(input logic func, input logic [7:0] b);
    step_words.delete();
    if (func) begin
      clear_session();
      if (startup_en) begin
        push_triplet(TN_WILL, OPTN_NAWS);
        push_triplet(TN_DONT, OPTN_ECHO);
        push_triplet(TN_WILL, OPTN_TTYPE);
      end
    end else if (parse_st == 2'd0) begin
      if (b == TN_IAC) parse_st = 2'd1;
      else if (b == CH_BEL) push_word(K_BELL, 8'd0, 1'b0);
      else push_word(K_DISPLAY, b, 1'b0);
    end else if (parse_st == 2'd1) begin
      if (b == TN_IAC) begin
        push_word(K_DISPLAY, b, 1'b0);
        parse_st = 2'd0;
      end else if (b == TN_WILL || b == TN_WONT || b == TN_DO || b == TN_DONT) begin
        held_verb = b;
        parse_st = 2'd2;
      end else if (b == TN_SB) begin
        sub_iac = 1'b0;
        parse_st = 2'd3;
      end else begin
        parse_st = 2'd0;
        if (b == TN_AYT) begin
          for (int i = 0; i < AytLen; i++)
            push_word(K_TX, AYT_STR[(AytLen - 1 - i) * 8 +: 8], 1'b0);
        end else if (b == TN_GA) begin
          push_word(K_GA, 8'd0, 1'b0);
        end
      end
    end else if (parse_st == 2'd2) begin
      parse_st = 2'd0;
      answer_option(held_verb, b);
      held_verb = 8'd0;
    end else begin
      if (sub_iac) begin
        sub_iac = 1'b0;
        if (b == TN_SE) parse_st = 2'd0;
      end else if (b == TN_IAC) begin
        sub_iac = 1'b1;
      end
    end
    if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
  endfunction

  // Sends one word and waits for its acceptance; the expectation is queued at
  // the accepting edge, ahead of any result it can cause. Valid stays high
  // after acceptance until the next word or a pause takes it down.
  task automatic send_word(input logic func, input logic [7:0] b,
                           input bit has_exp, input word_t exp_word);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.func    <= func;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    predict_telnet(func, b);
    if (has_exp && (step_words.size() == 0 || step_words[0] !== exp_word))
      report_mismatch("directed row", step_words.size() ? step_words[0] : '0, exp_word);
    foreach (step_words[i]) expected_words.push_back(step_words[i]);
  endtask

  task automatic drain_and_settle();
    in_ch.valid <= 1'b0;
    while (expected_words.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_startup(input logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    startup_en = v;
  endtask

  function automatic logic [7:0] pick_option();
    case ($urandom_range(0, 9))
      0: return OPTN_ECHO;
      1: return OPTN_SGA;
      2: return OPTN_STATUS;
      3: return OPTN_TMARK;
      4: return OPTN_TTYPE;
      5: return OPTN_NAWS;
      6: return 8'd255;
      7: return 8'd0;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_verb();
    case ($urandom_range(0, 3))
      0: return TN_WILL;
      1: return TN_WONT;
      2: return TN_DO;
      default: return TN_DONT;
    endcase
  endfunction

  // One random sequence with random content; returns the number of words sent.
  task automatic send_sequence(output int sent);
    int n;
    sent = 0;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        send_word(1'b0, TN_IAC, 1'b0, '0);
        send_word(1'b0, pick_verb(), 1'b0, '0);
        send_word(1'b0, pick_option(), 1'b0, '0);
        sent = 3;
      end
      3: begin
        send_word(1'b0, TN_IAC, 1'b0, '0);
        send_word(1'b0, TN_SB, 1'b0, '0);
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) send_word(1'b0, 8'($urandom_range(0, 255)), 1'b0, '0);
        send_word(1'b0, TN_IAC, 1'b0, '0);
        send_word(1'b0, TN_SE, 1'b0, '0);
        sent = n + 4;
      end
      4: begin
        send_word(1'b0, TN_IAC, 1'b0, '0);
        case ($urandom_range(0, 5))
          0: send_word(1'b0, TN_AYT, 1'b0, '0);
          1: send_word(1'b0, TN_GA, 1'b0, '0);
          2: send_word(1'b0, TN_SE, 1'b0, '0);
          3: send_word(1'b0, TN_IAC, 1'b0, '0);
          default: send_word(1'b0, 8'($urandom_range(0, 255)), 1'b0, '0);
        endcase
        sent = 2;
      end
      5: begin
        send_word(1'b0, CH_BEL, 1'b0, '0);
        sent = 1;
      end
      6: begin
        send_word(1'b1, 8'($urandom_range(0, 255)), 1'b0, '0);
        sent = 1;
      end
      default: begin
        send_word(1'b0, 8'($urandom_range(0, 255)), 1'b0, '0);
        sent = 1;
      end
    endcase
  endtask

  // Directed table: reset state, extremes, commands and special cases.
  row_t directed [] = '{
    '{1'b0, 8'h00,   1'b1, '{K_DISPLAY, 8'h00, 1'b0, 1'b1}},
    '{1'b0, 8'hFE,   1'b1, '{K_DISPLAY, 8'hFE, 1'b0, 1'b1}},
    '{1'b0, CH_BEL,  1'b1, '{K_BELL, 8'h00, 1'b0, 1'b1}},
    '{1'b0, TN_IAC,  1'b0, '0},
    '{1'b0, TN_IAC,  1'b1, '{K_DISPLAY, 8'hFF, 1'b0, 1'b1}},
    '{1'b0, TN_IAC,  1'b0, '0},
    '{1'b0, TN_GA,   1'b1, '{K_GA, 8'h00, 1'b0, 1'b1}},
    '{1'b0, TN_IAC,  1'b0, '0},
    '{1'b0, TN_AYT,  1'b1, '{K_TX, "I", 1'b0, 1'b0}},
    '{1'b0, TN_IAC,  1'b0, '0},
    '{1'b0, TN_SE,   1'b0, '0},
    '{1'b0, TN_IAC,  1'b0, '0},
    '{1'b0, 8'd241,  1'b0, '0},
    '{1'b0, TN_IAC,  1'b0, '0},
    '{1'b0, TN_WILL, 1'b0, '0},
    '{1'b0, OPTN_ECHO, 1'b1, '{K_TX, TN_IAC, 1'b0, 1'b0}},
    '{1'b0, TN_IAC,  1'b0, '0},
    '{1'b0, TN_WONT, 1'b0, '0},
    '{1'b0, OPTN_ECHO, 1'b0, '0},
    '{1'b0, TN_IAC,  1'b0, '0},
    '{1'b0, TN_DO,   1'b0, '0},
    '{1'b0, OPTN_TMARK, 1'b0, '0},
    '{1'b0, TN_IAC,  1'b0, '0},
    '{1'b0, TN_SB,   1'b0, '0},
    '{1'b0, TN_IAC,  1'b0, '0}
  };

  // Result side: random stall per word, plus one long hold-off so the
  // command queue fills and the input stalls.
  initial begin
    word_t got;
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end
      stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      got = '{out_ch.kind, out_ch.byte_value, out_ch.echo_local, out_ch.last};
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", got, '0);
      end else begin
        word_t want;
        want = expected_words.pop_front();
        if (got.kind !== want.kind) report_mismatch("kind", got, want);
        else if (got.byte_value !== want.byte_value) report_mismatch("byte_value", got, want);
        else if (got.echo_local !== want.echo_local) report_mismatch("echo_local", got, want);
        else if (got.last !== want.last) report_mismatch("last", got, want);
      end
    end
  end

  // Watchdog: cycles without any accepted word on either channel.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 5000) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    int total;
    mismatch_count = 0;
    long_hold = 1'b0;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.func    <= 1'b0;
    in_ch.rx_byte <= 8'd0;
    startup_en = 1'b0;
    echo_st = 1'b0;
    clear_session();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_startup(1'b0);
    foreach (directed[i])
      send_word(directed[i].func, directed[i].rx_byte, directed[i].has_exp,
                directed[i].exp_word);
    // Connect with startup offers disabled causes nothing; then enable them.
    send_word(1'b1, 8'hFF, 1'b0, '0);
    drain_and_settle();
    write_startup(1'b1);
    send_word(1'b1, 8'h00, 1'b1, '{K_TX, TN_IAC, 1'b0, 1'b0});

    // Random part, with a mid-run flip of the register and the pressure cases.
    total = 0;
    while (total < 360) begin
      if (total >= 120 && total < 130) begin
        drain_and_settle();
        write_startup(1'b0);
        total = 130;
      end
      if (total >= 240 && total < 250) begin
        drain_and_settle();
        write_startup(1'b1);
        long_hold = 1'b1;
        // Keep offering AYT bursts while the receiver holds off.
        for (int i = 0; i < 8; i++) begin
          send_word(1'b0, TN_IAC, 1'b0, '0);
          send_word(1'b0, TN_AYT, 1'b0, '0);
        end
        total = 266;
      end
      send_sequence(sent);
      total += sent;
    end

    drain_and_settle();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/trn_pkg.sv
hdl/trn_in_if.sv
hdl/trn_out_if.sv
hdl/trn_ram.sv
hdl/trn_front.sv
hdl/trn_queue.sv
hdl/trn_back.sv
hdl/telnet_receive_negotiator_top.sv
dv/tb_top.sv
